// File: rtl/core/rieu_pkg.sv
`default_nettype none
package rieu_pkg;

  localparam int unsigned RegCount   = 16;
  localparam int unsigned RegIdxW    = 4;
  localparam int unsigned MemWords   = 4096;
  localparam int unsigned MemAddrW   = 12;
  localparam int unsigned DataW      = 32;
  localparam int unsigned PcW        = 16;
  localparam int unsigned OpW        = 5;
  localparam int unsigned DivCntW    = 6;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADDL  = 5'd1,
    OP_SUB   = 5'd2,
    OP_SUBL  = 5'd3,
    OP_MUL   = 5'd4,
    OP_DIV   = 5'd5,
    OP_AND   = 5'd6,
    OP_OR    = 5'd7,
    OP_XOR   = 5'd8,
    OP_MOVC  = 5'd9,
    OP_LOAD  = 5'd10,
    OP_LDR   = 5'd11,
    OP_STORE = 5'd12,
    OP_STR   = 5'd13,
    OP_BZ    = 5'd14,
    OP_BNZ   = 5'd15,
    OP_CMP   = 5'd16,
    OP_NOP   = 5'd17,
    OP_HALT  = 5'd18
  } op_t;

  typedef struct packed {
    logic [OpW-1:0]     command;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src_a;
    logic [RegIdxW-1:0] src_b;
    logic [RegIdxW-1:0] src_c;
    logic [DataW-1:0]   immediate;
    logic [PcW-1:0]     instr_pc;
  } in_word_t;

  typedef struct packed {
    logic               reg_written;
    logic [RegIdxW-1:0] written_reg;
    logic [DataW-1:0]   written_value;
    logic               zero_out;
    logic               branch_taken;
    logic [PcW-1:0]     target_pc;
    logic               halted;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture input word, read register file
    logic exec;       // operands valid: start alu / address memory
    logic div_step;   // one restoring divide step
    logic finish;     // produce result word, write back
    logic clr_step;   // clear one memory word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic is_mem_rd;
    logic div_last;
    logic clr_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/rieu_if.sv
`default_nettype none
interface rieu_in_if;
  logic                 valid;
  logic                 ready;
  rieu_pkg::in_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rieu_out_if;
  logic                 valid;
  logic                 ready;
  rieu_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rieu_ram.sv
`default_nettype none
module rieu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/rieu_ctrl.sv
`default_nettype none
module rieu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rieu_pkg::dp_stat_t stat,
  output rieu_pkg::dp_cmd_t       cmd
);
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_DIV   = 6'b001000,
    S_MEM   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register is free when empty or being taken
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_div) state_nxt = S_DIV;
        else if (stat.is_mem_rd) state_nxt = S_MEM;
        else state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_MEM: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/rieu_dpath.sv
`default_nettype none
module rieu_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rieu_pkg::in_word_t  in_data,
  input  wire rieu_pkg::dp_cmd_t   cmd,
  output rieu_pkg::dp_stat_t       stat,
  output rieu_pkg::out_word_t      out_data
);
  localparam int unsigned DW = rieu_pkg::DataW;
  localparam int unsigned AW = rieu_pkg::MemAddrW;

  rieu_pkg::in_word_t  ins_r;
  logic [DW-1:0]       rf_r [rieu_pkg::RegCount];
  logic [DW-1:0]       va_r, vb_r, vc_r;
  logic                zero_r, zero_nxt;
  logic [DW-1:0]       res_r, res_nxt;
  logic [AW-1:0]       clr_addr_r;
  logic                clr_done_r;
  rieu_pkg::out_word_t out_r;
  rieu_pkg::op_t       op;

  // divider state
  logic [DW-1:0]       quo_r, rem_r, dvs_r;
  logic                dneg_r, dzero_r;
  logic [rieu_pkg::DivCntW-1:0] dcnt_r;
  logic [DW:0]         rem_sh, rem_sub;

  // memory port
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [DW-1:0]       mem_wdata, mem_rdata;
  logic [DW-1:0]       addr_sum;

  logic [2*DW-1:0]     prod;
  logic                is_alu, is_load;
  logic [DW-1:0]       wb_value;

  assign op = rieu_pkg::op_t'(ins_r.command);

  // opcode classes
  always_comb begin
    is_alu  = 1'b0;
    is_load = 1'b0;
    unique case (op)
      rieu_pkg::OP_ADD, rieu_pkg::OP_ADDL, rieu_pkg::OP_SUB, rieu_pkg::OP_SUBL,
      rieu_pkg::OP_MUL, rieu_pkg::OP_DIV, rieu_pkg::OP_AND, rieu_pkg::OP_OR,
      rieu_pkg::OP_XOR, rieu_pkg::OP_MOVC: is_alu = 1'b1;
      rieu_pkg::OP_LOAD, rieu_pkg::OP_LDR: is_load = 1'b1;
      default: ;
    endcase
  end

  assign stat.is_div    = (op == rieu_pkg::OP_DIV);
  assign stat.is_mem_rd = is_load;
  assign stat.div_last  = (dcnt_r == rieu_pkg::DivCntW'(DW - 1));
  assign stat.clr_done  = clr_done_r;

  // memory address: register plus register or immediate
  always_comb begin
    case (op)
      rieu_pkg::OP_LOAD:  addr_sum = va_r + ins_r.immediate;
      rieu_pkg::OP_STORE: addr_sum = vb_r + ins_r.immediate;
      default:            addr_sum = va_r + vb_r;
    endcase
  end

  assign mem_raddr = addr_sum[AW-1:0];
  assign mem_we    = cmd.clr_step ||
                     (cmd.exec && (op == rieu_pkg::OP_STORE || op == rieu_pkg::OP_STR));
  assign mem_waddr = cmd.clr_step ? clr_addr_r : addr_sum[AW-1:0];
  assign mem_wdata = cmd.clr_step ? '0 :
                     ((op == rieu_pkg::OP_STR) ? vc_r : va_r);

  rieu_ram #(.Width(DW), .Depth(rieu_pkg::MemWords)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign prod = va_r * vb_r;

  // combinational alu result
  always_comb begin
    case (op)
      rieu_pkg::OP_ADD:  res_nxt = va_r + vb_r;
      rieu_pkg::OP_ADDL: res_nxt = va_r + ins_r.immediate;
      rieu_pkg::OP_SUB:  res_nxt = va_r - vb_r;
      rieu_pkg::OP_SUBL: res_nxt = va_r - ins_r.immediate;
      rieu_pkg::OP_MUL:  res_nxt = prod[DW-1:0];
      rieu_pkg::OP_AND:  res_nxt = va_r & vb_r;
      rieu_pkg::OP_OR:   res_nxt = va_r | vb_r;
      rieu_pkg::OP_XOR:  res_nxt = va_r ^ vb_r;
      rieu_pkg::OP_MOVC: res_nxt = ins_r.immediate;
      default:           res_nxt = '0;
    endcase
  end

  // restoring divide step on magnitudes
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // write-back value, divide by zero gives zero
  assign wb_value = stat.is_div ? (dzero_r ? '0 : (dneg_r ? -quo_r : quo_r)) :
                    (is_load ? mem_rdata : res_r);

  // zero flag update
  always_comb begin
    zero_nxt = zero_r;
    if (op == rieu_pkg::OP_CMP) zero_nxt = (va_r == vb_r);
    else if (stat.is_div) zero_nxt = dzero_r || (quo_r == '0);
    else if (is_alu) zero_nxt = (res_r == '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r     <= 1'b0;
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
      dcnt_r     <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(rieu_pkg::MemWords - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.exec) dcnt_r <= '0;
      else if (cmd.div_step) dcnt_r <= dcnt_r + 1'b1;
      if (cmd.finish) zero_r <= zero_nxt;
    end
  end

  // operand fetch, divide and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rieu_pkg::RegCount; i++) rf_r[i] <= '0;
    end else if (cmd.finish && (is_alu || is_load)) begin
      rf_r[ins_r.dest_reg] <= wb_value;
    end
    if (cmd.latch_in) begin
      ins_r <= in_data;
      va_r  <= rf_r[in_data.src_a];
      vb_r  <= rf_r[in_data.src_b];
      vc_r  <= rf_r[in_data.src_c];
    end
    if (cmd.exec) begin
      res_r   <= res_nxt;
      quo_r   <= va_r[DW-1] ? -va_r : va_r;
      dvs_r   <= vb_r[DW-1] ? -vb_r : vb_r;
      rem_r   <= '0;
      dneg_r  <= va_r[DW-1] ^ vb_r[DW-1];
      dzero_r <= (vb_r == '0);
    end else if (cmd.div_step) begin
      if (!rem_sub[DW]) begin
        rem_r <= rem_sub[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_r.reg_written   <= is_alu || is_load;
      out_r.written_reg   <= (is_alu || is_load) ? ins_r.dest_reg : '0;
      out_r.written_value <= (is_alu || is_load) ? wb_value : '0;
      out_r.zero_out      <= zero_nxt;
      out_r.branch_taken  <= (op == rieu_pkg::OP_BZ && zero_r) ||
                             (op == rieu_pkg::OP_BNZ && !zero_r);
      out_r.target_pc     <= ((op == rieu_pkg::OP_BZ && zero_r) ||
                              (op == rieu_pkg::OP_BNZ && !zero_r)) ?
                             (ins_r.instr_pc + ins_r.immediate[rieu_pkg::PcW-1:0]) : '0;
      out_r.halted        <= (op == rieu_pkg::OP_HALT);
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

// File: rtl/core/risc_instruction_execute_unit.sv
`default_nettype none
// Execute unit of a small in-order risc core: one decoded instruction word in,
// one result word out, strictly in program order.
// in_ channel: command, register numbers, immediate and instruction pc.
// out_ channel: register write report, zero flag, branch decision, halt.
// Sequence: accept, execute, finish into the result register. Loads pass
// through an extra memory state for the registered ram read; div runs
// 32 restoring steps, one per quotient bit, between execute and finish.
// One instruction is in flight at a time and in_ready returns in the cycle
// after finish, so a new word is only taken once the last one has finished;
// the result register lets the next word be accepted while out_valid waits.
// Reset clears the register file and zero flag at once, then sweeps the
// 4096-word data memory to zero, one word a cycle, and in_ready stays low
// until the sweep is done.
// If the receiver stalls, the finished instruction holds until the result
// register frees, and no new word is taken meanwhile.
module risc_instruction_execute_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  rieu_in_if.sink   in_ch,
  rieu_out_if.source out_ch
);
  rieu_pkg::dp_cmd_t  cmd;
  rieu_pkg::dp_stat_t stat;

  rieu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rieu_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_ch.data)
  );

  // no write-back without a result being produced
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid) else $error("finish without out_valid");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping datapath commands");

  // memory clearing never overlaps accepting
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ch.ready) else $error("accept during clear");
endmodule
`default_nettype wire

// File: tb/sv/tb_channels.sv
`timescale 1ns / 100ps
`default_nettype none
// nothing extra: the channel interfaces come with the rtl file rieu_if.sv
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import rieu_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk;
  logic rst_n;

  rieu_in_if  in_ch ();
  rieu_out_if out_ch ();

  risc_instruction_execute_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow architectural state
  logic [DataW-1:0] shadow_regs [RegCount];
  logic [DataW-1:0] shadow_mem [MemWords];
  logic             shadow_zero;

  out_word_t expected_words [$];
  int unsigned fail_count;
  int unsigned result_count;
  int unsigned stall_cycles;
  int unsigned sent_count;
  bit          no_idle;
  bit          run_done;
  int unsigned op_seen [32];

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [DataW-1:0] quotient_of(logic [DataW-1:0] num,
                                                   logic [DataW-1:0] den);
    logic [DataW-1:0] mag_n;
    logic [DataW-1:0] mag_d;
    logic [DataW-1:0] q;
    if (den == '0) return '0;
    mag_n = num[DataW-1] ? -num : num;
    mag_d = den[DataW-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[DataW-1] ^ den[DataW-1]) ? -q : q;
  endfunction

  // work out the result word and update the shadow state
  function automatic out_word_t execute_word(in_word_t w);
    out_word_t r;
    logic [DataW-1:0] va;
    logic [DataW-1:0] vb;
    logic [DataW-1:0] vc;
    logic [DataW-1:0] res;
    logic alu;
    logic wr;
    logic taken;
    va = shadow_regs[w.src_a];
    vb = shadow_regs[w.src_b];
    vc = shadow_regs[w.src_c];
    res = '0;
    alu = 1'b1;
    wr = 1'b0;
    taken = 1'b0;
    case (op_t'(w.command))
      OP_ADD:  res = va + vb;
      OP_ADDL: res = va + w.immediate;
      OP_SUB:  res = va - vb;
      OP_SUBL: res = va - w.immediate;
      OP_MUL:  res = va * vb;
      OP_DIV:  res = quotient_of(va, vb);
      OP_AND:  res = va & vb;
      OP_OR:   res = va | vb;
      OP_XOR:  res = va ^ vb;
      OP_MOVC: res = w.immediate;
      default: alu = 1'b0;
    endcase
    if (alu) begin
      wr = 1'b1;
      shadow_zero = (res == '0);
    end else begin
      case (op_t'(w.command))
        OP_LOAD: begin
          res = shadow_mem[MemAddrW'(va + w.immediate)];
          wr = 1'b1;
        end
        OP_LDR: begin
          res = shadow_mem[MemAddrW'(va + vb)];
          wr = 1'b1;
        end
        OP_STORE: shadow_mem[MemAddrW'(vb + w.immediate)] = va;
        OP_STR:   shadow_mem[MemAddrW'(va + vb)] = vc;
        OP_BZ:    taken = shadow_zero;
        OP_BNZ:   taken = ~shadow_zero;
        OP_CMP:   shadow_zero = (va == vb);
        default: ;
      endcase
    end
    if (wr) shadow_regs[w.dest_reg] = res;
    r.reg_written   = wr;
    r.written_reg   = wr ? w.dest_reg : '0;
    r.written_value = wr ? res : '0;
    r.zero_out      = shadow_zero;
    r.branch_taken  = taken;
    r.target_pc     = taken ? PcW'(w.instr_pc + w.immediate[PcW-1:0]) : '0;
    r.halted        = (w.command == OP_HALT);
    return r;
  endfunction

  // send one word, with random idle cycles in front unless no_idle is set
  task automatic send_word(in_word_t w);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_words.push_back(execute_word(w));
    op_seen[w.command]++;
    sent_count++;
  endtask

  function automatic in_word_t make_word(logic [OpW-1:0] cmd, int unsigned rd,
                                         int unsigned ra, int unsigned rb,
                                         int unsigned rc, logic [DataW-1:0] imm);
    in_word_t w;
    w.command   = cmd;
    w.dest_reg  = RegIdxW'(rd);
    w.src_a     = RegIdxW'(ra);
    w.src_b     = RegIdxW'(rb);
    w.src_c     = RegIdxW'(rc);
    w.immediate = imm;
    w.instr_pc  = PcW'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_word(bit any_op);
    in_word_t w;
    w.command   = OpW'($urandom);
    w.dest_reg  = RegIdxW'($urandom);
    w.src_a     = RegIdxW'($urandom);
    w.src_b     = RegIdxW'($urandom);
    w.src_c     = RegIdxW'($urandom);
    w.immediate = DataW'($urandom);
    w.instr_pc  = PcW'($urandom);
    if (!any_op) w.command = OpW'($urandom_range(OP_HALT));
    // mostly small immediates so addresses land near stored data
    if ($urandom_range(3) != 0) w.immediate = DataW'($urandom_range(64)) - 32'd32;
    return w;
  endfunction

  // receiver: random stalls unless no_idle is set, compare against oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word %h", $realtime, out_ch.data);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.data !== exp_w) begin
            fail_count++;
            $display("%0t: result word expected %h actual %h", $realtime, exp_w,
                     out_ch.data);
            if (out_ch.data.written_value !== exp_w.written_value)
              $display("%0t: written_value expected %h actual %h", $realtime,
                       exp_w.written_value, out_ch.data.written_value);
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 10);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || run_done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WatchdogLimit) begin
      $display("risc_instruction_execute_unit: mismatch");
      $finish;
    end
  end

  // arithmetic edge values
  task automatic test_alu_extremes();
    send_word(make_word(OP_MOVC, 1, 0, 0, 0, 32'h8000_0000));
    send_word(make_word(OP_MOVC, 2, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(make_word(OP_MOVC, 3, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(OP_DIV, 4, 1, 2, 0, '0));   // overflow case
    send_word(make_word(OP_DIV, 5, 3, 0, 0, '0));   // divide by zero
    send_word(make_word(OP_DIV, 6, 1, 3, 0, '0));
    send_word(make_word(OP_ADD, 7, 3, 3, 0, '0));
    send_word(make_word(OP_SUB, 8, 1, 3, 0, '0));
    send_word(make_word(OP_MUL, 9, 1, 2, 0, '0));
    send_word(make_word(OP_ADDL, 10, 2, 0, 0, 32'd1));
    send_word(make_word(OP_SUBL, 11, 1, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(OP_AND, 12, 2, 3, 0, '0));
    send_word(make_word(OP_OR, 13, 1, 3, 0, '0));
    send_word(make_word(OP_XOR, 14, 2, 2, 0, '0));
  endtask

  // memory, branches, compare, halt and unused opcodes
  task automatic test_memory_branch();
    send_word(make_word(OP_STORE, 0, 3, 2, 0, 32'd5));     // wraps to 4
    send_word(make_word(OP_LOAD, 15, 0, 0, 0, 32'd4));
    send_word(make_word(OP_STR, 0, 1, 2, 3, '0));
    send_word(make_word(OP_LDR, 0, 1, 2, 0, '0));
    send_word(make_word(OP_CMP, 0, 1, 1, 0, '0));
    send_word(make_word(OP_BZ, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(make_word(OP_BNZ, 0, 0, 0, 0, 32'd8));
    send_word(make_word(OP_CMP, 0, 1, 2, 0, '0));
    send_word(make_word(OP_BNZ, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(OP_NOP, 0, 0, 0, 0, '0));
    send_word(make_word(OP_HALT, 0, 0, 0, 0, '0));
    send_word(make_word(5'd31, 15, 15, 15, 15, 32'hFFFF_FFFF));
  endtask

  // random programmes: a run without idling, then a longer one with idling
  task automatic test_random_programme(int unsigned count, bit quiet);
    no_idle = quiet;
    repeat (count) send_word(random_word($urandom_range(19) == 0));
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned drain;
    int unsigned ops_hit;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    result_count = 0;
    sent_count = 0;
    stall_cycles = 0;
    no_idle = 1'b0;
    run_done = 1'b0;
    ops_hit = 0;
    for (int i = 0; i < RegCount; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MemWords; i++) shadow_mem[i] = '0;
    shadow_zero = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alu_extremes();
    test_memory_branch();
    test_random_programme(300, 1'b1);
    test_random_programme(775, 1'b0);
    in_ch.valid <= 1'b0;

    drain = 0;
    while (expected_words.size() != 0 && drain < WatchdogLimit) begin
      @(posedge clk);
      drain++;
    end
    run_done = 1'b1;
    repeat (50) @(posedge clk);
    for (int i = 0; i < 32; i++) if (op_seen[i] != 0) ops_hit++;
    $display("run: %0d words sent, %0d results checked, %0d opcodes exercised",
             sent_count, result_count, ops_hit);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("risc_instruction_execute_unit: match");
    end else begin
      $display("risc_instruction_execute_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: risc_instruction_execute_unit.f
rtl/core/rieu_pkg.sv
rtl/core/rieu_if.sv
rtl/core/rieu_ram.sv
rtl/core/rieu_ctrl.sv
rtl/core/rieu_dpath.sv
rtl/core/risc_instruction_execute_unit.sv
tb/sv/tb_channels.sv
tb/sv/tb.sv
